/* sv/rotating_point_trail_defines.svh */
// assertion macros for the rotating point trail
`ifndef ROTATING_POINT_TRAIL_DEFINES_SVH
`define ROTATING_POINT_TRAIL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rpt_pkg.sv */
// shared types and constants of the rotating point trail
`default_nettype none
package rpt_pkg;

  localparam int TRAIL_DEPTH = 64;
  localparam int SLOT_W      = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TRAIL_DEPTH + 1);
  localparam int POS_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } rpt_state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rpt_point_t;

  typedef struct packed {
    logic signed [17:0] cos_a;
    logic signed [17:0] sin_a;
    logic signed [18:0] omc;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } rpt_cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              last;
  } rpt_tag_t;

endpackage
`default_nettype wire

/* sv/rpt_ifs.sv */
// valid/ready channel interfaces for trail points and rotated results
`default_nettype none
interface rpt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;

  modport source (output valid, output new_x, output new_y, output new_z, input ready);
  modport sink   (input valid, input new_x, input new_y, input new_z, output ready);
endinterface

interface rpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [5:0]         position;
  logic               is_last;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output position, output is_last, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input position, input is_last, output ready);
endinterface
`default_nettype wire

/* sv/rotating_point_trail.sv */
// top level: trail memory, run sequencer, configuration and result register
//
//  channel  dir  payload                               handshake
//  in_pt    in   new_x new_y new_z                     valid/ready
//  out_pt   out  out_x out_y out_z position is_last    valid/ready
//  cfg      in   cfg_index cfg_data                    cfg_we, no wait
//
// each input beat starts a run over the trail: the sequencer reads one stored
// point per cycle through the single memory read port into a 7-stage rotate pipe
// a stall on out_pt freezes the memory read, the pipe and the sequencer together
// in_pt is ready once the pipe has drained, even while the last result waits
// reset clears the control and configuration; trail contents stay undefined
`default_nettype none
`include "rotating_point_trail_defines.svh"
module rotating_point_trail (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rpt_in_if.sink                              in_pt,
  rpt_out_if.source                           out_pt,
  input  wire logic                           cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpt_pkg::*;

  rpt_cfg_t          cfg_r;
  rpt_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, iss_cnt_r, run_len_r;
  logic [SLOT_W-1:0] oldest_r, iss_slot_r;

  rpt_point_t        mem [TRAIL_DEPTH];
  rpt_point_t        rd_r;
  logic              v1_r;
  rpt_tag_t          tag1_r;

  logic              en, in_acc, iss_go, iss_end, busy, dp_busy, dp_vld, wb_en;
  rpt_tag_t          dp_tag;
  rpt_point_t        dp_res;

  logic              out_valid_r;
  rpt_point_t        out_pt_r;
  rpt_tag_t          out_tag_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_a <= 18'sd65536;
      cfg_r.sin_a <= '0;
      cfg_r.omc   <= '0;
      cfg_r.ax    <= '0;
      cfg_r.ay    <= '0;
      cfg_r.az    <= 18'sd65536;
      cfg_r.cx    <= '0;
      cfg_r.cy    <= '0;
      cfg_r.cz    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS: begin
          cfg_r.cos_a <= $signed(cfg_data[17:0]);
          cfg_r.omc   <= 19'sd65536 - 19'($signed(cfg_data[17:0]));
        end
        REG_SIN:      cfg_r.sin_a <= $signed(cfg_data[17:0]);
        REG_AXIS_X:   cfg_r.ax    <= $signed(cfg_data[17:0]);
        REG_AXIS_Y:   cfg_r.ay    <= $signed(cfg_data[17:0]);
        REG_AXIS_Z:   cfg_r.az    <= $signed(cfg_data[17:0]);
        REG_CENTRE_X: cfg_r.cx    <= $signed(cfg_data);
        REG_CENTRE_Y: cfg_r.cy    <= $signed(cfg_data);
        REG_CENTRE_Z: cfg_r.cz    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign en      = !out_valid_r || out_pt.ready;
  assign busy    = v1_r || dp_busy;
  assign in_acc  = in_pt.valid && in_pt.ready;
  assign iss_end = (iss_cnt_r == run_len_r - CNT_W'(1));
  assign wb_en   = en && dp_vld;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_pt.valid) state_nxt = ST_RUN;
      ST_RUN:   if (en && iss_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_pt.ready = 1'b0;
    iss_go      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_pt.ready = 1'b1;
      ST_RUN:   iss_go      = en;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  // append slot for the new point
  logic [CNT_W:0]    app_sum;
  logic [SLOT_W-1:0] app_slot, oldest_inc, oldest_nxt;
  logic [CNT_W-1:0]  fill_nxt;
  logic              full;

  always_comb begin
    full    = (fill_r == CNT_W'(TRAIL_DEPTH));
    app_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(fill_r);
    if (app_sum >= (CNT_W+1)'(TRAIL_DEPTH)) begin
      app_sum = app_sum - (CNT_W+1)'(TRAIL_DEPTH);
    end
    oldest_inc = (oldest_r == SLOT_W'(TRAIL_DEPTH - 1)) ? '0 : oldest_r + SLOT_W'(1);
    if (full) begin
      app_slot   = oldest_r;
      oldest_nxt = oldest_inc;
      fill_nxt   = fill_r;
    end else begin
      app_slot   = app_sum[SLOT_W-1:0];
      oldest_nxt = oldest_r;
      fill_nxt   = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      oldest_r   <= '0;
      iss_cnt_r  <= '0;
      iss_slot_r <= '0;
      run_len_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        fill_r     <= fill_nxt;
        oldest_r   <= oldest_nxt;
        run_len_r  <= fill_nxt;
        iss_cnt_r  <= '0;
        iss_slot_r <= oldest_nxt;
      end else if (iss_go) begin
        iss_cnt_r  <= iss_cnt_r + CNT_W'(1);
        iss_slot_r <= (iss_slot_r == SLOT_W'(TRAIL_DEPTH - 1)) ? '0
                                                               : iss_slot_r + SLOT_W'(1);
      end
    end
  end

  // trail memory: one write port shared by append and write-back, one read port
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  rpt_point_t        mem_wd;

  always_comb begin
    mem_we = in_acc || wb_en;
    if (in_acc) begin
      mem_wa = app_slot;
      mem_wd = '{x: in_pt.new_x, y: in_pt.new_y, z: in_pt.new_z};
    end else begin
      mem_wa = dp_tag.slot;
      mem_wd = dp_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r        <= mem[iss_slot_r];
      tag1_r.slot <= iss_slot_r;
      tag1_r.pos  <= POS_W'(iss_cnt_r);
      tag1_r.last <= iss_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= iss_go;
    end
  end

  rpt_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (v1_r),
    .tag_in  (tag1_r),
    .pt_in   (rd_r),
    .cfg     (cfg_r),
    .vld_out (dp_vld),
    .tag_out (dp_tag),
    .res_out (dp_res),
    .busy    (dp_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      out_pt_r  <= dp_res;
      out_tag_r <= dp_tag;
    end
  end

  assign out_pt.valid    = out_valid_r;
  assign out_pt.out_x    = out_pt_r.x;
  assign out_pt.out_y    = out_pt_r.y;
  assign out_pt.out_z    = out_pt_r.z;
  assign out_pt.position = out_tag_r.pos;
  assign out_pt.is_last  = out_tag_r.last;

  `RPT_ASSERT_NEXT(a_accept_starts_run, in_acc, state_r == ST_RUN, "beat did not start a run")
  `RPT_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(TRAIL_DEPTH), "fill count over depth")
  `RPT_ASSERT_NOW(a_no_wb_idle, state_r == ST_IDLE, !wb_en && !busy, "write-back while idle")
  `RPT_ASSERT_NOW(a_issue_bound, state_r == ST_RUN, iss_cnt_r < run_len_r, "issue past run length")

endmodule
`default_nettype wire

/* sv/rpt_rotate.sv */
// pipelined rodrigues rotation of one trail point per cycle while en is high
`default_nettype none
module rpt_rotate (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_in,
  input  wire rpt_pkg::rpt_tag_t    tag_in,
  input  wire rpt_pkg::rpt_point_t  pt_in,
  input  wire rpt_pkg::rpt_cfg_t    cfg,
  output logic                      vld_out,
  output rpt_pkg::rpt_tag_t         tag_out,
  output rpt_pkg::rpt_point_t       res_out,
  output logic                      busy
);
  import rpt_pkg::*;

  logic signed [17:0] k [3];
  logic signed [31:0] c [3];
  logic signed [31:0] p [3];

  assign k[0] = cfg.ax;
  assign k[1] = cfg.ay;
  assign k[2] = cfg.az;
  assign c[0] = cfg.cx;
  assign c[1] = cfg.cy;
  assign c[2] = cfg.cz;
  assign p[0] = pt_in.x;
  assign p[1] = pt_in.y;
  assign p[2] = pt_in.z;

  logic [7:2]  v_r;
  rpt_tag_t    tag_r [2:8];

  logic signed [32:0] d_r    [3];
  logic signed [50:0] mdot_r [3];
  logic signed [50:0] mca_r  [3];
  logic signed [50:0] mcb_r  [3];
  logic signed [50:0] dc3_r  [3];
  logic signed [35:0] cr_r   [3];
  logic signed [50:0] dc4_r  [3];
  logic signed [54:0] kdp_r  [3];
  logic signed [53:0] cs5_r  [3];
  logic signed [50:0] dc5_r  [3];
  logic signed [38:0] kd_r   [3];
  logic signed [53:0] cs6_r  [3];
  logic signed [50:0] dc6_r  [3];
  logic signed [57:0] kdo_r  [3];
  logic signed [53:0] cs7_r  [3];
  logic signed [50:0] dc7_r  [3];
  logic signed [43:0] r_r    [3];
  logic signed [36:0] dot_r;
  logic               v8_r;

  logic signed [52:0] dot_sum;
  logic signed [36:0] dot_nxt;

  always_comb begin
    dot_sum = 53'(mdot_r[0]) + 53'(mdot_r[1]) + 53'(mdot_r[2]) + 53'sd32768;
    dot_nxt = dot_sum[52:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      v8_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[6:2], vld_in};
      v8_r <= v_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[2] <= tag_in;
      for (int s = 3; s <= 8; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
      dot_r <= dot_nxt;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int L1 = (l + 1) % 3;
    localparam int L2 = (l + 2) % 3;

    logic signed [51:0] cr_sum;
    logic signed [54:0] kd_sum;
    logic signed [59:0] r_sum;
    logic signed [44:0] tot;

    always_comb begin
      cr_sum = 52'(mca_r[l]) - 52'(mcb_r[l]) + 52'sd32768;
      kd_sum = kdp_r[l] + 55'sd32768;
      r_sum  = 60'(dc7_r[l]) + 60'(cs7_r[l]) + 60'(kdo_r[l]) + 60'sd32768;
      tot    = 45'(c[l]) + 45'(r_r[l]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[l]    <= 33'(p[l]) - 33'(c[l]);
        mdot_r[l] <= 51'(d_r[l]) * 51'(k[l]);
        mca_r[l]  <= 51'(k[L1]) * 51'(d_r[L2]);
        mcb_r[l]  <= 51'(k[L2]) * 51'(d_r[L1]);
        dc3_r[l]  <= 51'(d_r[l]) * 51'(cfg.cos_a);
        cr_r[l]   <= cr_sum[51:16];
        dc4_r[l]  <= dc3_r[l];
        kdp_r[l]  <= 55'(k[l]) * 55'(dot_r);
        cs5_r[l]  <= 54'(cr_r[l]) * 54'(cfg.sin_a);
        dc5_r[l]  <= dc4_r[l];
        kd_r[l]   <= kd_sum[54:16];
        cs6_r[l]  <= cs5_r[l];
        dc6_r[l]  <= dc5_r[l];
        kdo_r[l]  <= 58'(kd_r[l]) * 58'(cfg.omc);
        cs7_r[l]  <= cs6_r[l];
        dc7_r[l]  <= dc6_r[l];
        r_r[l]    <= r_sum[59:16];
      end
    end

    logic signed [31:0] sat;
    always_comb begin
      if (tot > 45'sd2147483647) begin
        sat = 32'sh7fffffff;
      end else if (tot < -45'sd2147483648) begin
        sat = 32'sh80000000;
      end else begin
        sat = tot[31:0];
      end
    end

    if (l == 0) begin : g_x
      assign res_out.x = sat;
    end else if (l == 1) begin : g_y
      assign res_out.y = sat;
    end else begin : g_z
      assign res_out.z = sat;
    end
  end

  assign vld_out = v8_r;
  assign tag_out = tag_r[8];
  assign busy    = (|v_r) | v8_r;

endmodule
`default_nettype wire

/* test/rotating_point_trail_test.sv */
// testbench for rotating_point_trail: directed table, then random phases vs a predictor
`timescale 1ns / 100ps
module rotating_point_trail_test;
  import rpt_pkg::*;

  localparam int ANGLE_W        = 18;
  localparam int I_MAX          = 2147483647;
  localparam int I_MIN          = int'(32'h8000_0000);
  localparam int N_PHASES       = 6;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 100;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int N_DIR          = 37;

  typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    logic signed [31:0]   px, py, pz;
    logic                 typed;
    logic signed [31:0]   ex, ey, ez;
  } dir_row_t;

  typedef struct packed {
    logic               typed;
    logic signed [31:0] x, y, z;
  } newest_note_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [POS_W-1:0]   pos;
    logic               last;
  } trail_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rpt_in_if  in_pt();
  rpt_out_if out_pt();

  rotating_point_trail dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_pt),
    .out_pt    (out_pt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // rotation settings and trail contents as the block should hold them
  longint k_cos = 65536, k_sin = 0;
  longint k_ax = 0, k_ay = 0, k_az = 65536;
  longint k_cx = 0, k_cy = 0, k_cz = 0;
  int mem_x [TRAIL_DEPTH];
  int mem_y [TRAIL_DEPTH];
  int mem_z [TRAIL_DEPTH];
  int unsigned head_slot = 0;
  int unsigned trail_len = 0;

  trail_beat_t  rotated_q [$];
  newest_note_t newest_q [$];

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit hold_rx = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_POINT, REG_COS, 32'h0, 0, 0, 0, 1'b1, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, I_MAX, I_MIN, -1, 1'b1, I_MAX, I_MIN, -1},
    '{ROW_POINT, REG_COS, 32'h0, I_MIN, I_MAX, 1, 1'b1, I_MIN, I_MAX, 1},
    '{ROW_POINT, REG_COS, 32'h0, 65536, -65536, 32'sh7FFF_8000,
      1'b1, 65536, -65536, 32'sh7FFF_8000},
    '{ROW_WRITE, REG_COS, 32'h0000_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SIN, 32'h0001_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 1, 2, 3, 1'b1, -2, 1, 3},
    '{ROW_POINT, REG_COS, 32'h0, I_MIN, 5, 0, 1'b1, -5, I_MIN, 0},
    '{ROW_POINT, REG_COS, 32'h0, 5, I_MIN, 7, 1'b1, I_MAX, 5, 7},
    '{ROW_POINT, REG_COS, 32'h0, I_MAX, I_MAX, I_MAX, 1'b1, -I_MAX, I_MAX, I_MAX},
    '{ROW_WRITE, REG_COS,      32'h0002_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SIN,      32'h0001_FFFF, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_X,   32'h0002_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_Y,   32'h0001_FFFF, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_Z,   32'hFFFF_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_X, 32'h8000_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_Y, 32'h7FFF_FFFF, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_Z, 32'h0000_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, I_MAX, I_MIN, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, I_MIN, I_MAX, I_MAX, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, -1, -1, -1, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_8000,
      1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COS,      32'hFFFC_B505, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SIN,      32'hABC0_B505, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_X,   32'h0000_93CD, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_Y,   32'h0000_93CD, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_AXIS_Z,   32'h0000_93CD, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_X, 32'h0010_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_Y, 32'hFFE0_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_CENTRE_Z, 32'h0005_0000, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 32'sh0001_8000, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 0, 32'sh0001_8000, -32'sh0000_8000, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 32'sh0000_7FFF, 32'sh0000_8001, 1, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, -32'sh0020_0000, 32'sh0003_0000, -32'sh0001_0000,
      1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, I_MAX, 0, I_MIN, 1'b0, 0, 0, 0},
    '{ROW_POINT, REG_COS, 32'h0, 32'sh00AB_CDEF, -32'sh0012_3456, 32'sh0100_0000,
      1'b0, 0, 0, 0}
  };

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic int clamp32(longint v);
    if (v > longint'(I_MAX)) return I_MAX;
    if (v < longint'(I_MIN)) return I_MIN;
    return int'(v);
  endfunction

  function automatic void rotate_slot(int unsigned s);
    longint dx, dy, dz, dot, crx, cry, crz, omc, rx, ry, rz;
    dx = longint'(mem_x[s]) - k_cx;
    dy = longint'(mem_y[s]) - k_cy;
    dz = longint'(mem_z[s]) - k_cz;
    dot = round_q16(dx * k_ax + dy * k_ay + dz * k_az);
    crx = round_q16(k_ay * dz - k_az * dy);
    cry = round_q16(k_az * dx - k_ax * dz);
    crz = round_q16(k_ax * dy - k_ay * dx);
    omc = 64'sd65536 - k_cos;
    rx = round_q16(dx * k_cos + crx * k_sin + round_q16(k_ax * dot) * omc);
    ry = round_q16(dy * k_cos + cry * k_sin + round_q16(k_ay * dot) * omc);
    rz = round_q16(dz * k_cos + crz * k_sin + round_q16(k_az * dot) * omc);
    mem_x[s] = clamp32(k_cx + rx);
    mem_y[s] = clamp32(k_cy + ry);
    mem_z[s] = clamp32(k_cz + rz);
  endfunction

  // append the new point, turn the whole trail, queue it oldest first
  function automatic void advance_trail(int nx, int ny, int nz, newest_note_t note);
    int unsigned slot;
    int unsigned s;
    trail_beat_t beat;
    if (trail_len < TRAIL_DEPTH) begin
      slot = (head_slot + trail_len) % TRAIL_DEPTH;
      trail_len++;
    end else begin
      slot = head_slot;
      head_slot = (head_slot + 1) % TRAIL_DEPTH;
    end
    mem_x[slot] = nx;
    mem_y[slot] = ny;
    mem_z[slot] = nz;
    for (int i = 0; i < int'(trail_len); i++) begin
      s = (head_slot + i) % TRAIL_DEPTH;
      rotate_slot(s);
      beat.x = mem_x[s];
      beat.y = mem_y[s];
      beat.z = mem_z[s];
      beat.pos = POS_W'(i);
      beat.last = (i + 1 == int'(trail_len));
      if (beat.last && note.typed) begin
        beat.x = note.x;
        beat.y = note.y;
        beat.z = note.z;
      end
      rotated_q.insert(rotated_q.size(), beat);
    end
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic newest_note_t take_note();
    newest_note_t n;
    n = newest_q[0];
    newest_q.delete(0);
    return n;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_pt.valid && in_pt.ready)
      advance_trail(in_pt.new_x, in_pt.new_y, in_pt.new_z, take_note());
  end

  always @(posedge clk) begin : result_check
    trail_beat_t want;
    if (rst_n && out_pt.valid && out_pt.ready) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: beat with nothing expected, actual x=%0d y=%0d z=%0d pos=%0d",
                 $time, out_pt.out_x, out_pt.out_y, out_pt.out_z, out_pt.position);
        mismatches++;
      end else begin
        want = rotated_q[0];
        rotated_q.delete(0);
        check_field("out_x", want.x, out_pt.out_x);
        check_field("out_y", want.y, out_pt.out_y);
        check_field("out_z", want.z, out_pt.out_z);
        check_field("position", want.pos, out_pt.position);
        check_field("is_last", want.last, out_pt.is_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : sink_side
    out_pt.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_rx) begin
        out_pt.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_pt.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_pt.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer_point(input int x, input int y, input int z,
                             input logic typed, input int ex, input int ey, input int ez);
    newest_note_t note;
    note = '{typed, ex, ey, ez};
    newest_q.insert(newest_q.size(), note);
    in_pt.valid <= 1'b1;
    in_pt.new_x <= x;
    in_pt.new_y <= y;
    in_pt.new_z <= z;
    do @(posedge clk); while (!in_pt.ready);
  endtask

  task automatic sender_gap();
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_pt.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_trail();
    in_pt.valid <= 1'b0;
    do @(posedge clk); while (rotated_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_COS:      k_cos = longint'($signed(data[ANGLE_W-1:0]));
      REG_SIN:      k_sin = longint'($signed(data[ANGLE_W-1:0]));
      REG_AXIS_X:   k_ax = longint'($signed(data[ANGLE_W-1:0]));
      REG_AXIS_Y:   k_ay = longint'($signed(data[ANGLE_W-1:0]));
      REG_AXIS_Z:   k_az = longint'($signed(data[ANGLE_W-1:0]));
      REG_CENTRE_X: k_cx = longint'($signed(data));
      REG_CENTRE_Y: k_cy = longint'($signed(data));
      REG_CENTRE_Z: k_cz = longint'($signed(data));
      default: ;
    endcase
  endtask

  function automatic int rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return int'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
    if (pick < 9) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return I_MAX;
      1: return I_MIN;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int rand_centre();
    if ($urandom_range(0, 3) != 0)
      return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    return int'($urandom);
  endfunction

  task automatic load_random_setting();
    real ang;
    int c, s;
    int axv [3];
    ang = $urandom_range(0, 6283) / 1000.0;
    c = $rtoi($cos(ang) * 65536.0);
    s = $rtoi($sin(ang) * 65536.0);
    // raw patterns now and then, upper bits included
    if ($urandom_range(0, 3) == 0) begin
      c = int'($urandom);
      s = int'($urandom);
    end
    case ($urandom_range(0, 2))
      0: begin
        axv = '{0, 0, 0};
        axv[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 65536 : -65536;
      end
      1: begin
        foreach (axv[i]) axv[i] = $urandom_range(0, 1) ? 37837 : -37837;
      end
      default: begin
        foreach (axv[i]) axv[i] = int'($urandom);
      end
    endcase
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    write_reg(REG_AXIS_X, axv[0]);
    write_reg(REG_AXIS_Y, axv[1]);
    write_reg(REG_AXIS_Z, axv[2]);
    write_reg(REG_CENTRE_X, rand_centre());
    write_reg(REG_CENTRE_Y, rand_centre());
    write_reg(REG_CENTRE_Z, rand_centre());
    cfg_we <= 1'b0;
  endtask

  initial begin : source_side
    in_pt.valid <= 1'b0;
    in_pt.new_x <= '0;
    in_pt.new_y <= '0;
    in_pt.new_z <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_COS;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_pct = 20;
    rx_stall_pct = 15;
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_WRITE) drain_trail();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        if (i == N_DIR - 1 || dir_rows[i+1].kind != ROW_WRITE) cfg_we <= 1'b0;
      end else begin
        sender_gap();
        offer_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz, dir_rows[i].typed,
                    dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_trail();
      load_random_setting();
      if (ph == N_PHASES - 1) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 40);
        rx_stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 30);
      end
      // receiver holds off while the sender keeps pushing, so the input backs up
      if (ph == 2) begin
        tx_gap_pct = 0;
        hold_rx = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        sender_gap();
        offer_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 0, 0, 0);
      end
    end

    drain_trail();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
